/* rtl/lsch_pkg.sv */
// ----------------------------------------------------------------------------
// lsch_pkg
// Types and constants shared by the lottery scheduler modules.
// ----------------------------------------------------------------------------
package lsch_pkg;

  // Fixed field widths
  localparam int SLOT_W = 6;
  localparam int TICK_W = 7;
  localparam int RND_W  = 32;
  // Cell index and ticket sum sized for the largest slot table (256 slots)
  localparam int IDX_W  = 8;
  localparam int SUM_W  = 15;

  // Configuration register reset values
  localparam logic [TICK_W-1:0] RESET_INITIAL = 7'd20;
  localparam logic [TICK_W-1:0] RESET_MAX     = 7'd100;

  // Configuration register indexes
  localparam logic CFG_INITIAL = 1'b0;
  localparam logic CFG_MAX     = 1'b1;

  // Event commands
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_STOP    = 2'd1;
  localparam logic [1:0] CMD_QUANTUM = 2'd2;
  localparam logic [1:0] CMD_NICE    = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_TIX  = 2'd1;
  localparam logic [1:0] ST_NOT_USE = 2'd2;

  // Write broadcast to the cell row
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic              in_use;
    logic              winq;
    logic [TICK_W-1:0] tickets;
  } cell_wr_t;

  // State one cell shows to the control
  typedef struct packed {
    logic              in_use;
    logic              winq;
    logic [TICK_W-1:0] tickets;
  } cell_st_t;

  // Lottery wave travelling down the cell row
  typedef struct packed {
    logic             act;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [SUM_W-1:0] w;
  } wave_t;

  // One queued result
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              winq;
    logic [1:0]        status;
  } res_t;

endpackage

/* rtl/lsch_if.sv */
// ----------------------------------------------------------------------------
// lsch_if
// Valid/ready channels for scheduler requests and queue placements.
// ----------------------------------------------------------------------------
interface lsch_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [5:0]  slot;
  logic [6:0]  nice_amount;
  logic [31:0] random_value;

  modport source (output valid, cmd, slot, nice_amount, random_value, input ready);
  modport sink   (input valid, cmd, slot, nice_amount, random_value, output ready);
endinterface

interface lsch_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] target_slot;
  logic       to_winner_queue;
  logic [1:0] status;
  logic       last;

  modport source (output valid, target_slot, to_winner_queue, status, last, input ready);
  modport sink   (input valid, target_slot, to_winner_queue, status, last, output ready);
endinterface

/* rtl/lsch_cell.sv */
// ----------------------------------------------------------------------------
// lsch_cell
// One slot of the table: holds tickets and flags, and passes the lottery
// wave on to the next cell through a register.
// ----------------------------------------------------------------------------
module lsch_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lsch_pkg::cell_wr_t wr_i,
  input  lsch_pkg::wave_t    wave_i,
  output lsch_pkg::wave_t    wave_o,
  output lsch_pkg::cell_st_t st_o
);

  localparam logic [lsch_pkg::IDX_W-1:0] MY_IDX = lsch_pkg::IDX_W'(IDX);

  logic                        in_use_r;
  logic                        winq_r;
  logic [lsch_pkg::TICK_W-1:0] tickets_r;
  lsch_pkg::wave_t             wave_r;
  lsch_pkg::wave_t             wave_nxt;
  logic [lsch_pkg::SUM_W-1:0]  tix_ext;
  logic                        hit;

  // Hold slot state, take broadcast writes aimed at this slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r  <= 1'b0;
      winq_r    <= 1'b0;
      tickets_r <= '0;
    end else if (wr_i.en && wr_i.idx == MY_IDX) begin
      in_use_r  <= wr_i.in_use;
      winq_r    <= wr_i.winq;
      tickets_r <= wr_i.tickets;
    end
  end

  // Compare the draw with this slot's tickets, subtract when passing over
  assign tix_ext = lsch_pkg::SUM_W'(tickets_r);
  assign hit     = wave_i.act && !wave_i.found && in_use_r && (wave_i.w < tix_ext);

  always_comb begin
    wave_nxt = wave_i;
    if (hit) begin
      wave_nxt.found = 1'b1;
      wave_nxt.idx   = MY_IDX;
    end else if (!wave_i.found && in_use_r) begin
      wave_nxt.w = wave_i.w - tix_ext;
    end
  end

  // Advance the wave one cell per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r.act <= 1'b0;
    end else begin
      wave_r.act <= wave_nxt.act;
    end
    wave_r.found <= wave_nxt.found;
    wave_r.idx   <= wave_nxt.idx;
    wave_r.w     <= wave_nxt.w;
  end

  assign wave_o = wave_r;
  assign st_o   = '{in_use: in_use_r, winq: winq_r, tickets: tickets_r};

endmodule

/* rtl/lsch_div.sv */
// ----------------------------------------------------------------------------
// lsch_div
// Restoring remainder unit: draw modulo ticket sum, one bit per cycle.
// ----------------------------------------------------------------------------
module lsch_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [lsch_pkg::RND_W-1:0]  dividend_i,
  input  logic [lsch_pkg::SUM_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [lsch_pkg::SUM_W-1:0]  rem_o
);

  localparam int CNT_W = $clog2(lsch_pkg::RND_W);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [lsch_pkg::RND_W-1:0] dvd_r;
  logic [lsch_pkg::SUM_W-1:0] dvs_r;
  logic [lsch_pkg::SUM_W-1:0] rem_r;
  logic [lsch_pkg::SUM_W:0]   trial;
  logic [lsch_pkg::SUM_W:0]   diff;

  // Shift in the next dividend bit and subtract when it fits
  assign trial = {rem_r, dvd_r[lsch_pkg::RND_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(lsch_pkg::RND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      dvd_r <= dividend_i;
      dvs_r <= divisor_i;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[lsch_pkg::RND_W-2:0], 1'b0};
      if (!diff[lsch_pkg::SUM_W]) begin
        rem_r <= diff[lsch_pkg::SUM_W-1:0];
      end else begin
        rem_r <= trial[lsch_pkg::SUM_W-1:0];
      end
    end
  end

  assign done_o = done_r;
  assign rem_o  = rem_r;

endmodule

/* rtl/lottery_scheduler_top.sv */
// ----------------------------------------------------------------------------
// lottery_scheduler_top
// Lottery scheduler over a row of slot cells with a serial remainder unit.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// in_ch    in   cmd, slot, nice_amount, random_value (one event per request)
// out_ch   out  target_slot, to_winner_queue, status, last (1 to 3 per event)
// cfg_*    in   write enable, index (0 initial, 1 max), 7-bit data
//
// Start, stop and nice: the request is latched, the slots are read (S_RD) and
// the command is executed (S_EXEC) before the result is offered (S_OUT).
// Quantum expiry: the remainder unit loads the draw, then works one bit a cycle,
// and the lottery wave then crosses the cell row. With a zero ticket sum the
// remainder unit is skipped and the wave finds no winner.
// The queued results then go out in order; out_ch stalls hold them.
// One event is in work at a time; in_ch.ready is high only when idle.
// Reset is synchronous and clears every slot at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lottery_scheduler_top #(
  parameter int NUM_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  lsch_in_if.sink     in_ch,
  lsch_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [6:0]  cfg_data
);

  localparam int IW = lsch_pkg::IDX_W;
  localparam int SW = lsch_pkg::SUM_W;
  localparam int TW = lsch_pkg::TICK_W;
  localparam logic [8:0] NSL = 9'(NUM_SLOTS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_EXEC = 6'b000100,
    S_DIV  = 6'b001000,
    S_SCAN = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [TW-1:0] init_r, max_r;

  logic [1:0]           cmd_r;
  logic [5:0]           slot_r;
  logic [TW-1:0]        amt_r;
  logic [31:0]          rnd_r;
  logic [SW-1:0]        sum_r, sum_nxt;
  logic [IW-1:0]        lw_r, lw_nxt;
  logic                 lwv_r, lwv_nxt;
  lsch_pkg::cell_st_t   rd_s_r, rd_l_r, sel_s, sel_l;
  lsch_pkg::res_t       res_r [3];
  lsch_pkg::res_t       res0_nxt, res1_nxt;
  logic                 res0_we, res1_we;
  logic [1:0]           cnt_r, cnt_nxt, ptr_r, ptr_nxt;
  logic                 launch_r, launch_nxt;
  logic                 div_start, div_done;
  logic [SW-1:0]        div_rem;

  lsch_pkg::cell_wr_t   wr;
  lsch_pkg::cell_st_t   cst  [NUM_SLOTS];
  lsch_pkg::wave_t      wave [NUM_SLOTS+1];

  logic [IW-1:0]        sidx;
  logic                 in_range, lw_hit;
  logic [TW:0]          nice_sum;
  logic [TW-1:0]        nice_t;
  lsch_pkg::wave_t      tail;

  assign sidx     = IW'(slot_r);
  assign in_range = {3'b0, slot_r} < NSL;
  assign lw_hit   = lwv_r && (lw_r == sidx);
  assign tail     = wave[NUM_SLOTS];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= lsch_pkg::RESET_INITIAL;
      max_r  <= lsch_pkg::RESET_MAX;
    end else if (cfg_we) begin
      if (cfg_idx == lsch_pkg::CFG_INITIAL) init_r <= cfg_data;
      else if (cfg_idx == lsch_pkg::CFG_MAX) max_r <= cfg_data;
    end
  end

  // Cell row, lottery wave enters at the head
  assign wave[0] = '{act: launch_r, found: 1'b0, idx: '0, w: div_rem};

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    lsch_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr_i   (wr),
      .wave_i (wave[g]),
      .wave_o (wave[g+1]),
      .st_o   (cst[g])
    );
  end

  // Select the requested slot and the last winner from the row
  always_comb begin
    sel_s = '0;
    sel_l = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sidx == IW'(i)) sel_s = sel_s | cst[i];
      if (lw_r == IW'(i)) sel_l = sel_l | cst[i];
    end
  end

  lsch_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (rnd_r),
    .divisor_i  (sum_nxt),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign nice_sum = {1'b0, rd_s_r.tickets} + {1'b0, amt_r};
  assign nice_t   = (nice_sum > {1'b0, max_r}) ? max_r : nice_sum[TW-1:0];

  // Event sequencing
  always_comb begin
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    lw_nxt     = lw_r;
    lwv_nxt    = lwv_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    launch_nxt = 1'b0;
    div_start  = 1'b0;
    wr         = '0;
    res0_we    = 1'b0;
    res1_we    = 1'b0;
    res0_nxt   = '0;
    res1_nxt   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        res0_we   = 1'b1;
        res0_nxt  = '{slot: slot_r, winq: 1'b0, status: lsch_pkg::ST_OK};
        cnt_nxt   = 2'd1;
        ptr_nxt   = 2'd0;
        state_nxt = S_OUT;
        if (cmd_r == lsch_pkg::CMD_START) begin
          if (in_range) begin
            wr = '{en: 1'b1, idx: sidx, in_use: 1'b1, winq: 1'b0, tickets: init_r};
            sum_nxt = sum_r - (rd_s_r.in_use ? SW'(rd_s_r.tickets) : '0) + SW'(init_r);
            if (lw_hit) lwv_nxt = 1'b0;
          end else begin
            res0_nxt.status = lsch_pkg::ST_NOT_USE;
          end
        end else if (!(in_range && rd_s_r.in_use)) begin
          res0_nxt.status = lsch_pkg::ST_NOT_USE;
        end else if (cmd_r == lsch_pkg::CMD_STOP) begin
          wr = '{en: 1'b1, idx: sidx, in_use: 1'b0, winq: 1'b0, tickets: '0};
          sum_nxt = sum_r - SW'(rd_s_r.tickets);
          if (lw_hit) lwv_nxt = 1'b0;
        end else if (cmd_r == lsch_pkg::CMD_NICE) begin
          wr = '{en: 1'b1, idx: sidx, in_use: 1'b1, winq: rd_s_r.winq, tickets: nice_t};
          sum_nxt = sum_r - SW'(rd_s_r.tickets) + SW'(nice_t);
          res0_nxt.winq = rd_s_r.winq;
        end else begin
          // Quantum expiry: demote, then run the lottery
          if (rd_s_r.winq) begin
            wr = '{en: 1'b1, idx: sidx, in_use: 1'b1, winq: 1'b0,
                   tickets: rd_s_r.tickets};
            if (rd_s_r.tickets > TW'(1)) begin
              wr.tickets = rd_s_r.tickets - 1'b1;
              sum_nxt    = sum_r - 1'b1;
            end
          end else if (lwv_r && rd_l_r.in_use) begin
            wr = '{en: 1'b1, idx: lw_r, in_use: 1'b1, winq: 1'b0,
                   tickets: rd_l_r.tickets};
            res0_nxt.slot = lw_r[5:0];
            if (rd_l_r.tickets < max_r) begin
              wr.tickets = rd_l_r.tickets + 1'b1;
              sum_nxt    = sum_r + 1'b1;
            end
          end else begin
            res0_we = 1'b0;
            cnt_nxt = 2'd0;
          end
          if (sum_nxt == '0) begin
            // No live tickets: the wave finds no winner, skip the remainder
            launch_nxt = 1'b1;
            state_nxt  = S_SCAN;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          launch_nxt = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail.act) begin
          res0_we  = 1'b1;
          res1_we  = 1'b1;
          res1_nxt = '{slot: slot_r, winq: tail.found && (tail.idx == sidx),
                       status: lsch_pkg::ST_OK};
          if (tail.found) begin
            wr = '{en: 1'b1, idx: tail.idx, in_use: 1'b1, winq: 1'b1,
                   tickets: cst[tail.idx[$clog2(NUM_SLOTS)-1:0]].tickets};
            lw_nxt   = tail.idx;
            lwv_nxt  = 1'b1;
            res0_nxt = '{slot: tail.idx[5:0], winq: 1'b1, status: lsch_pkg::ST_OK};
          end else begin
            res0_nxt = '{slot: '0, winq: 1'b0, status: lsch_pkg::ST_NO_TIX};
          end
          cnt_nxt   = cnt_r + 2'd2;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          ptr_nxt = ptr_r + 1'b1;
          if (ptr_r == cnt_r - 1'b1) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sum_r    <= '0;
      lw_r     <= '0;
      lwv_r    <= 1'b0;
      cnt_r    <= '0;
      ptr_r    <= '0;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sum_r    <= sum_nxt;
      lw_r     <= lw_nxt;
      lwv_r    <= lwv_nxt;
      cnt_r    <= cnt_nxt;
      ptr_r    <= ptr_nxt;
      launch_r <= launch_nxt;
    end
  end

  // Latch the request and the slot reads; queue results in order
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      cmd_r  <= in_ch.cmd;
      slot_r <= in_ch.slot;
      amt_r  <= in_ch.nice_amount;
      rnd_r  <= in_ch.random_value;
    end
    if (state_r == S_RD) begin
      rd_s_r <= sel_s;
      rd_l_r <= sel_l;
    end
    if (state_r == S_SCAN) begin
      if (res0_we) res_r[cnt_r]        <= res0_nxt;
      if (res1_we) res_r[cnt_r + 2'd1] <= res1_nxt;
    end else begin
      if (res0_we) res_r[0] <= res0_nxt;
      if (res1_we) res_r[res0_we ? 2'd1 : 2'd0] <= res1_nxt;
    end
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = (state_r == S_OUT);
  assign out_ch.target_slot     = res_r[ptr_r].slot;
  assign out_ch.to_winner_queue = res_r[ptr_r].winq;
  assign out_ch.status          = res_r[ptr_r].status;
  assign out_ch.last            = (ptr_r == cnt_r - 1'b1);

endmodule

/* tb/lottery_scheduler_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lottery_scheduler_top_tb
// Drives scheduler requests and register writes into the lottery scheduler,
// predicts every queue placement from a private copy of the slot table, and
// compares the placements field by field in order under random idling.
// ----------------------------------------------------------------------------

class placement_board;
  typedef struct {
    logic [5:0] slot;
    logic       winq;
    logic [1:0] status;
    logic       last;
  } place_t;

  int unsigned tix[64];
  bit          used[64];
  bit          winq[64];
  int unsigned tix_sum;
  int unsigned champ;
  bit          champ_ok;
  int unsigned init_tix;
  int unsigned max_tix;
  place_t      due_q[$];
  int          mismatches;

  function new();
    for (int i = 0; i < 64; i++) begin
      tix[i] = 0;
      used[i] = 1'b0;
      winq[i] = 1'b0;
    end
    tix_sum = 0;
    champ = 0;
    champ_ok = 1'b0;
    init_tix = lsch_pkg::RESET_INITIAL;
    max_tix = lsch_pkg::RESET_MAX;
    mismatches = 0;
  endfunction

  function void write_reg(logic idx, logic [6:0] val);
    if (idx == lsch_pkg::CFG_INITIAL) init_tix = val;
    else max_tix = val;
  endfunction

  function void push(int unsigned s, bit q, logic [1:0] st, ref place_t ev[$]);
    place_t p;
    p.slot = s[5:0];
    p.winq = q;
    p.status = st;
    p.last = 1'b0;
    ev.push_back(p);
  endfunction

  function void release_slot(int unsigned s);
    if (used[s]) tix_sum -= tix[s];
    used[s] = 1'b0;
    winq[s] = 1'b0;
    tix[s] = 0;
    if (champ_ok && champ == s) champ_ok = 1'b0;
  endfunction

  // Work out the placements one request causes and queue them
  function void note_request(logic [1:0] cmd, logic [5:0] s, logic [6:0] amt,
                             logic [31:0] rnd);
    place_t      ev[$];
    int unsigned t;
    int unsigned w;
    bit          found;
    found = 1'b0;
    if (cmd == lsch_pkg::CMD_START) begin
      release_slot(s);
      used[s] = 1'b1;
      tix[s] = init_tix;
      tix_sum += init_tix;
      push(s, 1'b0, lsch_pkg::ST_OK, ev);
    end else if (!used[s]) begin
      push(s, 1'b0, lsch_pkg::ST_NOT_USE, ev);
    end else if (cmd == lsch_pkg::CMD_STOP) begin
      release_slot(s);
      push(s, 1'b0, lsch_pkg::ST_OK, ev);
    end else if (cmd == lsch_pkg::CMD_NICE) begin
      t = tix[s] + amt;
      if (t > max_tix) t = max_tix;
      tix_sum = tix_sum - tix[s] + t;
      tix[s] = t;
      push(s, winq[s], lsch_pkg::ST_OK, ev);
    end else begin
      // Demote the expired winner, or the last winner when a loser blocked
      if (winq[s]) begin
        winq[s] = 1'b0;
        push(s, 1'b0, lsch_pkg::ST_OK, ev);
        if (tix[s] > 1) begin
          tix[s]--;
          tix_sum--;
        end
      end else if (champ_ok && used[champ]) begin
        winq[champ] = 1'b0;
        push(champ, 1'b0, lsch_pkg::ST_OK, ev);
        if (tix[champ] < max_tix) begin
          tix[champ]++;
          tix_sum++;
        end
      end
      // Draw the new winner by running subtraction in slot order
      if (tix_sum != 0) begin
        w = rnd % tix_sum;
        for (int i = 0; i < 64; i++) begin
          if (used[i]) begin
            if (w < tix[i]) begin
              winq[i] = 1'b1;
              champ = i;
              champ_ok = 1'b1;
              push(i, 1'b1, lsch_pkg::ST_OK, ev);
              found = 1'b1;
              break;
            end
            w -= tix[i];
          end
        end
      end
      if (!found) push(0, 1'b0, lsch_pkg::ST_NO_TIX, ev);
      push(s, winq[s], lsch_pkg::ST_OK, ev);
    end
    ev[ev.size()-1].last = 1'b1;
    foreach (ev[i]) due_q.push_back(ev[i]);
  endfunction

  function void check_result(logic [5:0] s, logic q, logic [1:0] st, logic lst);
    place_t e;
    if (due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected placement slot=%0d winq=%0b status=%0d last=%0b",
                 s, q, st, lst);
      return;
    end
    e = due_q.pop_front();
    if (s !== e.slot || q !== e.winq || st !== e.status || lst !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"ERROR: placement exp slot=%0d winq=%0b status=%0d last=%0b,",
                  " got slot=%0d winq=%0b status=%0d last=%0b"},
                 e.slot, e.winq, e.status, e.last, s, q, st, lst);
    end
  endfunction
endclass

module lottery_scheduler_top_tb;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_idx;
  logic [6:0] cfg_data;
  bit         send_gaps;
  bit         sink_stalls;
  int         cycles = 0;

  lsch_in_if  in_ch ();
  lsch_out_if out_ch ();
  placement_board board;

  lottery_scheduler_top #(.NUM_SLOTS(64)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Monitor both handshakes
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      board.note_request(in_ch.cmd, in_ch.slot, in_ch.nice_amount, in_ch.random_value);
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.target_slot, out_ch.to_winner_queue, out_ch.status,
                         out_ch.last);
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_ch.ready <= sink_stalls ? ($urandom_range(99) >= 24) : 1'b1;
  end

  task automatic send(logic [1:0] cmd, logic [5:0] s, logic [6:0] amt,
                      logic [31:0] rnd);
    @(negedge clk);
    while (send_gaps && $urandom_range(99) < 24) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd = cmd;
    in_ch.slot = s;
    in_ch.nice_amount = amt;
    in_ch.random_value = rnd;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
  endtask

  // Hold until every placement is in, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (board.due_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_requests(int n);
    logic [1:0] cmd;
    logic [5:0] s;
    int         pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      cmd = pick < 20 ? lsch_pkg::CMD_START :
            pick < 30 ? lsch_pkg::CMD_STOP :
            pick < 75 ? lsch_pkg::CMD_QUANTUM : lsch_pkg::CMD_NICE;
      s = ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
      send(cmd, s, ($urandom_range(1) ? 7'($urandom_range(127)) : 7'($urandom_range(4))),
           $urandom());
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = lsch_pkg::CFG_INITIAL;
    cfg_data = 7'd0;
    in_ch.valid = 1'b0;
    in_ch.cmd = lsch_pkg::CMD_START;
    in_ch.slot = 6'd0;
    in_ch.nice_amount = 7'd0;
    in_ch.random_value = 32'd0;
    send_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: unused slots, re-start, saturation, lottery extremes
    send(lsch_pkg::CMD_QUANTUM, 6'd5, 7'd0, 32'd0);
    send(lsch_pkg::CMD_STOP, 6'd63, 7'd127, 32'hFFFF_FFFF);
    send(lsch_pkg::CMD_NICE, 6'd42, 7'd127, 32'd0);
    send(lsch_pkg::CMD_START, 6'd0, 7'd0, 32'd0);
    send(lsch_pkg::CMD_START, 6'd63, 7'd0, 32'd0);
    send(lsch_pkg::CMD_QUANTUM, 6'd0, 7'd0, 32'hFFFF_FFFF);
    send(lsch_pkg::CMD_QUANTUM, 6'd0, 7'd0, 32'd0);
    send(lsch_pkg::CMD_QUANTUM, 6'd63, 7'd0, 32'd25);
    send(lsch_pkg::CMD_NICE, 6'd0, 7'd127, 32'd0);
    send(lsch_pkg::CMD_NICE, 6'd63, 7'd0, 32'd0);
    send(lsch_pkg::CMD_START, 6'd0, 7'd0, 32'd0);
    send(lsch_pkg::CMD_QUANTUM, 6'd63, 7'd0, 32'hAAAA_5555);
    send(lsch_pkg::CMD_STOP, 6'd0, 7'd0, 32'd0);
    send(lsch_pkg::CMD_QUANTUM, 6'd63, 7'd0, 32'h5555_AAAA);
    send(lsch_pkg::CMD_STOP, 6'd63, 7'd0, 32'd0);
    send(lsch_pkg::CMD_QUANTUM, 6'd63, 7'd0, 32'd0);

    // Zero initial tickets leaves the draw with nothing to pick
    write_reg(lsch_pkg::CFG_INITIAL, 7'd0);
    send(lsch_pkg::CMD_START, 6'd1, 7'd0, 32'd0);
    send(lsch_pkg::CMD_QUANTUM, 6'd1, 7'd0, 32'h1234_5678);
    send(lsch_pkg::CMD_NICE, 6'd1, 7'd3, 32'd0);
    send(lsch_pkg::CMD_QUANTUM, 6'd1, 7'd0, 32'hFFFF_FFFF);
    send(lsch_pkg::CMD_STOP, 6'd1, 7'd0, 32'd0);

    // Random phases across register settings, no idling first
    write_reg(lsch_pkg::CFG_INITIAL, 7'd127);
    write_reg(lsch_pkg::CFG_MAX, 7'd127);
    random_requests(20);
    send_gaps = 1'b1;
    sink_stalls = 1'b1;
    write_reg(lsch_pkg::CFG_INITIAL, 7'd1);
    write_reg(lsch_pkg::CFG_MAX, 7'd1);
    random_requests(20);
    write_reg(lsch_pkg::CFG_INITIAL, 7'd64);
    write_reg(lsch_pkg::CFG_MAX, 7'd127);
    random_requests(15);
    drain();
    random_requests(15);
    write_reg(lsch_pkg::CFG_INITIAL, 7'd20);
    write_reg(lsch_pkg::CFG_MAX, 7'd100);
    random_requests(30);

    // Finish: wait out the last placements
    drain();
    if (board.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
